// ----- sv/tcw_pkg.sv -----
// Shared codes and widths for the text console writer.
// Used by the top level and its checker; depends on nothing else.
package tcw_pkg;

  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int INDEX_W    = 11;
  localparam int ROW_OUT_W  = 5;
  localparam int COL_OUT_W  = 7;
  localparam int POS_OUT_W  = 11;
  localparam int CELL_W     = 16;
  localparam int ATTR_W     = 8;
  localparam int TAB_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [CHAR_W-1:0]    char_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam mode_t MODE_PUT   = 2'd0;
  localparam mode_t MODE_CLEAR = 2'd1;
  localparam mode_t MODE_READ  = 2'd2;

  localparam char_t CHAR_TAB     = 8'd9;
  localparam char_t CHAR_NEWLINE = 8'd10;
  localparam char_t CHAR_RETURN  = 8'd13;
  localparam char_t CHAR_BLANK   = 8'h20;

  localparam cfg_idx_t CFG_ATTR = 1'b0;
  localparam cfg_idx_t CFG_TAB  = 1'b1;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd13;
  localparam logic [TAB_W-1:0]  TAB_RESET  = 4'd4;

endpackage

// ----- sv/text_console_writer.sv -----
// Text console writer: character-cell screen store, cursor and sequencer.
// Depends on tcw_pkg for codes and field widths.
//
// Usage: one input word (mode, char_code, cell_index) is taken on the in_
// channel when in_valid is high and in_stall is low; each word gives exactly
// one result word on the out_ channel, taken when out_valid is high and
// out_stall is low. The block works on one word at a time and holds in_stall
// high from acceptance until its result has been taken.
// From acceptance, a put without scroll, a read or an unused mode passes
// through S_EXEC and S_POS, and out_valid is registered on entry to S_OUT.
// A clear sweeps every cell through the single memory write port. A put
// that scrolls copies ROWS*COLUMNS-COLUMNS cells (one read and one write a
// cycle) and then blanks the bottom row. With no stall on the output, a new
// word can be taken in the cycle after the result is taken.
// Reset (synchronous, active low) homes the cursor, loads the register
// defaults and empties the result stage; screen cells are not cleared.
// While the receiver stalls, the result word is held unchanged.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [INDEX_W-1:0]    in_cell_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ROW_OUT_W-1:0]  out_cursor_row,
  output logic [COL_OUT_W-1:0]  out_cursor_col,
  output logic [POS_OUT_W-1:0]  out_cursor_position,
  output logic [CELL_W-1:0]     out_cell_data,
  output logic                  out_scrolled,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int LIM   = CELLS - COLUMNS;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CSW   = CW + TAB_W;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_COPY  = 6'b000100,
    S_BLANK = 6'b001000,
    S_POS   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [RW-1:0]      row_r, row_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic               pend_r, pend_nxt;
  logic               scrl_r, scrl_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ATTR_W-1:0]  attr_r;
  logic [TAB_W-1:0]   tab_r;

  mode_t              mode_r;
  char_t              ch_r;
  logic [INDEX_W-1:0] idx_r;

  logic [ROW_OUT_W-1:0] o_row_r;
  logic [COL_OUT_W-1:0] o_col_r;
  logic [POS_OUT_W-1:0] o_pos_r;
  logic [CELL_W-1:0]    o_cell_r;
  logic                 o_scrl_r;

  logic [CELL_W-1:0] mem [CELLS];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] rd_data_r;

  logic              is_nl, is_cr, is_tab, wrap;
  logic [CSW-1:0]    col_step, col_sum;
  logic [AW-1:0]     cur_addr;
  logic [CELL_W-1:0] blank;
  logic              idx_ok;

  assign is_nl    = (ch_r == CHAR_NEWLINE);
  assign is_cr    = (ch_r == CHAR_RETURN);
  assign is_tab   = (ch_r == CHAR_TAB);
  assign col_step = is_tab ? CSW'(tab_r) : CSW'(1);
  assign col_sum  = CSW'(col_r) + col_step;
  assign wrap     = is_nl | (!is_cr & (col_sum >= CSW'(COLUMNS)));
  assign cur_addr = AW'(32'(row_r) * COLUMNS + 32'(col_r));
  assign blank    = {attr_r, CHAR_BLANK};
  assign idx_ok   = (32'(idx_r) < CELLS);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    scrl_nxt      = scrl_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(cnt_r);
    mem_wdata     = blank;
    mem_raddr     = AW'(idx_r);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
          scrl_nxt  = 1'b0;
        end
      end
      S_EXEC: begin
        state_nxt = S_POS;
        case (mode_r)
          MODE_PUT: begin
            if (!is_nl && !is_cr && !is_tab) begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {attr_r, ch_r};
            end
            if (is_cr) begin
              col_nxt = '0;
            end else if (wrap) begin
              col_nxt = '0;
              if (row_r == RW'(ROWS - 1)) begin
                // Bottom row overflowed: copy every row but the top one up, then blank the last.
                scrl_nxt  = 1'b1;
                cnt_nxt   = '0;
                state_nxt = S_COPY;
              end else begin
                row_nxt = row_r + RW'(1);
              end
            end else begin
              col_nxt = CW'(col_sum);
            end
          end
          MODE_CLEAR: begin
            row_nxt   = '0;
            col_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_BLANK;
          end
          default: begin
            state_nxt = S_POS;
          end
        endcase
      end
      S_COPY: begin
        // The cell read in the previous cycle lands one row higher up.
        mem_raddr = AW'(cnt_r + CNTW'(COLUMNS));
        mem_we    = pend_r;
        mem_waddr = AW'(cnt_r - CNTW'(1));
        mem_wdata = rd_data_r;
        if (cnt_r == CNTW'(LIM)) begin
          state_nxt = S_BLANK;
        end else begin
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r + CNTW'(1);
        end
      end
      S_BLANK: begin
        mem_we = 1'b1;
        if (cnt_r == CNTW'(CELLS - 1)) begin
          state_nxt = S_POS;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      S_POS: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      scrl_r      <= 1'b0;
      out_valid_r <= 1'b0;
      attr_r      <= ATTR_RESET;
      tab_r       <= TAB_RESET;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      scrl_r      <= scrl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATTR: attr_r <= cfg_data[ATTR_W-1:0];
          CFG_TAB:  tab_r  <= cfg_data[TAB_W-1:0];
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      mode_r <= in_mode;
      ch_r   <= in_char_code;
      idx_r  <= in_cell_index;
    end
    if (state_r == S_POS) begin
      o_row_r  <= ROW_OUT_W'(row_r);
      o_col_r  <= COL_OUT_W'(col_r);
      o_pos_r  <= POS_OUT_W'(32'(row_r) * COLUMNS + 32'(col_r));
      o_cell_r <= (mode_r == MODE_READ && idx_ok) ? rd_data_r : '0;
      o_scrl_r <= scrl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign out_cursor_row      = o_row_r;
  assign out_cursor_col      = o_col_r;
  assign out_cursor_position = o_pos_r;
  assign out_cell_data       = o_cell_r;
  assign out_scrolled        = o_scrl_r;

endmodule

// ----- sv/tcw_checker.sv -----
// Port-level checks for the text console writer, bound to its top level.
// Depends on tcw_pkg for the mode codes and field widths.
module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [MODE_W-1:0]    in_mode,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [ROW_OUT_W-1:0] out_cursor_row,
  input logic [COL_OUT_W-1:0] out_cursor_col,
  input logic [POS_OUT_W-1:0] out_cursor_position,
  input logic [CELL_W-1:0]    out_cell_data,
  input logic                 out_scrolled
);

  localparam bit POS_CHECK = (COLUMNS <= 128) && (ROWS <= 32);

  mode_t last_mode_r;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      last_mode_r <= in_mode;
    end
  end

  // A pending result blocks the next word.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("word accepted while a result is pending");

  a_pos_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (POS_CHECK && out_valid) |->
      out_cursor_position == POS_OUT_W'(32'(out_cursor_row) * COLUMNS + 32'(out_cursor_col)))
    else $error("linear cursor position disagrees with row and column");

  a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_scrolled) |-> out_cursor_col == '0)
    else $error("scroll left the cursor off column zero");

  a_data_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && last_mode_r != MODE_READ) |-> out_cell_data == '0)
    else $error("cell data on a word that was not a read");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_cursor_position)
      && $stable(out_cell_data)))
    else $error("stalled result word changed");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_mode            (in_mode),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_cursor_row     (out_cursor_row),
  .out_cursor_col     (out_cursor_col),
  .out_cursor_position(out_cursor_position),
  .out_cell_data      (out_cell_data),
  .out_scrolled       (out_scrolled)
);
